// ===== rtl/ubsd_pkg.sv =====
// package: shared types and constants of the unicode byte stream decoder
package ubsd_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int ST_W   = 2;
	localparam int FMT_W  = 3;
	localparam int ACC_W  = 32;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [FMT_W-1:0] FMT_UTF8    = 3'd0;
	localparam logic [FMT_W-1:0] FMT_UTF16LE = 3'd1;
	localparam logic [FMT_W-1:0] FMT_UTF16BE = 3'd2;
	localparam logic [FMT_W-1:0] FMT_UTF32LE = 3'd3;
	localparam logic [FMT_W-1:0] FMT_UTF32BE = 3'd4;

	localparam logic [15:0]      SURR_HI_MIN  = 16'hd800;
	localparam logic [15:0]      SURR_HI_MAX  = 16'hdbff;
	localparam logic [15:0]      SURR_LO_MIN  = 16'hdc00;
	localparam logic [15:0]      SURR_LO_MAX  = 16'hdfff;
	localparam logic [CP_W-1:0]  SUPP_BASE    = 21'h10000;
	localparam logic [ACC_W-1:0] CP_MAX       = 32'h0010ffff;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SURR = 2'd1,
		ST_TRUNC    = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LEAD_ONE   = 2'd0,
		LEAD_TWO   = 2'd1,
		LEAD_THREE = 2'd2,
		LEAD_FOUR  = 2'd3
	} lead_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		lead_t             lead;
	} item_t;

endpackage

// ===== rtl/ubsd_byte_if.sv =====
// interface: byte channel into the decoder
interface ubsd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [ubsd_pkg::BYTE_W-1:0]   in_byte;
	logic                          end_of_buffer;

	modport source(output valid, output in_byte, output end_of_buffer, input ready);
	modport sink(input valid, input in_byte, input end_of_buffer, output ready);
endinterface

// ===== rtl/ubsd_char_if.sv =====
// interface: code point channel out of the decoder
interface ubsd_char_if;
	logic                        valid;
	logic                        ready;
	logic [ubsd_pkg::CP_W-1:0]   code_point;
	logic [ubsd_pkg::ST_W-1:0]   status;
	logic                        last;

	modport source(output valid, output code_point, output status, output last, input ready);
	modport sink(input valid, input code_point, input status, input last, output ready);
endinterface

// ===== rtl/ubsd_front.sv =====
// front end: accepts bytes and classifies utf-8 lead length
module ubsd_front (
	ubsd_byte_if.sink          byte_ch,
	input  logic               q_full,
	output logic               q_push,
	output ubsd_pkg::item_t    q_item
);
	import ubsd_pkg::*;

	logic [BYTE_W-1:0] b;

	assign b             = byte_ch.in_byte;
	assign byte_ch.ready = !q_full;
	assign q_push        = byte_ch.valid && !q_full;

	always_comb begin
		q_item.data = b;
		q_item.last = byte_ch.end_of_buffer;
		if (b inside {[8'h00:8'h7f]}) begin
			q_item.lead = LEAD_ONE;
		end else if (b inside {[8'h80:8'hdf]}) begin
			q_item.lead = LEAD_TWO;
		end else if (b inside {[8'he0:8'hef]}) begin
			q_item.lead = LEAD_THREE;
		end else begin
			q_item.lead = LEAD_FOUR;
		end
	end
endmodule

// ===== rtl/ubsd_queue.sv =====
// short item queue between front end and back end
module ubsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ubsd_pkg::item_t    push_item,
	output logic               full,
	input  logic               pop,
	output ubsd_pkg::item_t    pop_item,
	output logic               not_empty
);
	import ubsd_pkg::*;

	item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

// ===== rtl/ubsd_back.sv =====
// back end: decoding state, code point assembly and output register
module ubsd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fmt_we,
	input  logic [ubsd_pkg::FMT_W-1:0]  fmt_wdata,
	input  logic                        q_valid,
	input  ubsd_pkg::item_t             q_item,
	output logic                        q_pop,
	ubsd_char_if.source                 char_ch
);
	import ubsd_pkg::*;

	logic [FMT_W-1:0]  fmt_q;
	logic [ACC_W-1:0]  acc_q, acc_d, acc_new;
	logic [1:0]        pend_q, pend_d;
	logic [1:0]        idx_q, idx_d;
	logic [9:0]        hi_q, hi_d;
	logic              sp_q, sp_d;
	logic              emit;
	logic [CP_W-1:0]   cp;
	status_t           st;
	logic [15:0]       unit;
	logic [ACC_W-1:0]  b_ext;
	logic              last_b;

	logic              out_valid_q;
	logic [CP_W-1:0]   cp_q;
	status_t           st_q;
	logic              last_q;

	assign q_pop  = q_valid && (!out_valid_q || char_ch.ready);
	assign b_ext  = {{(ACC_W - BYTE_W){1'b0}}, q_item.data};
	assign last_b = q_item.last;

	always_comb begin
		acc_d   = acc_q;
		pend_d  = pend_q;
		idx_d   = idx_q;
		hi_d    = hi_q;
		sp_d    = sp_q;
		emit    = 1'b0;
		cp      = '0;
		st      = ST_OK;
		acc_new = acc_q;
		unit    = '0;
		case (fmt_q)
			FMT_UTF16LE, FMT_UTF16BE: begin
				if (fmt_q == FMT_UTF16LE) begin
					acc_new = acc_q | (b_ext << {idx_q[0], 3'b000});
				end else begin
					acc_new = {16'b0, acc_q[7:0], q_item.data};
				end
				if (idx_q == 2'd0) begin
					idx_d = 2'd1;
					acc_d = acc_new;
					if (last_b) begin
						acc_d = '0; pend_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
						emit  = 1'b1;
						st    = ST_TRUNC;
					end
				end else begin
					unit  = acc_new[15:0];
					acc_d = '0;
					idx_d = '0;
					if (sp_q) begin
						sp_d = 1'b0;
						hi_d = '0;
						emit = 1'b1;
						if (unit >= SURR_LO_MIN && unit <= SURR_LO_MAX) begin
							cp = {1'b0, hi_q, unit[9:0]} + SUPP_BASE;
						end else begin
							st = ST_BAD_SURR;
						end
					end else if (unit >= SURR_HI_MIN && unit <= SURR_HI_MAX) begin
						if (last_b) begin
							emit = 1'b1;
							st   = ST_TRUNC;
						end else begin
							hi_d = unit[9:0];
							sp_d = 1'b1;
						end
					end else if (unit >= SURR_LO_MIN && unit <= SURR_LO_MAX) begin
						emit = 1'b1;
						st   = ST_BAD_SURR;
					end else begin
						emit = 1'b1;
						cp   = {5'b0, unit};
					end
					if (last_b) begin
						acc_d = '0; pend_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
					end
				end
			end
			FMT_UTF32LE, FMT_UTF32BE: begin
				if (fmt_q == FMT_UTF32LE) begin
					acc_new = acc_q | (b_ext << {idx_q, 3'b000});
				end else begin
					acc_new = {acc_q[ACC_W-BYTE_W-1:0], q_item.data};
				end
				if (idx_q != 2'd3) begin
					idx_d = idx_q + 2'd1;
					acc_d = acc_new;
					if (last_b) begin
						acc_d = '0; pend_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
						emit  = 1'b1;
						st    = ST_TRUNC;
					end
				end else begin
					acc_d = '0; pend_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
					emit  = 1'b1;
					if (acc_new > CP_MAX) begin
						st = ST_RANGE;
					end else begin
						cp = acc_new[CP_W-1:0];
					end
				end
			end
			default: begin
				if (pend_q == 2'd0) begin
					case (q_item.lead)
						LEAD_ONE: begin
							emit = 1'b1;
							cp   = {{(CP_W - BYTE_W){1'b0}}, q_item.data};
						end
						LEAD_TWO: begin
							acc_d  = {27'b0, q_item.data[4:0]};
							pend_d = 2'd1;
						end
						LEAD_THREE: begin
							acc_d  = {28'b0, q_item.data[3:0]};
							pend_d = 2'd2;
						end
						default: begin
							acc_d  = {29'b0, q_item.data[2:0]};
							pend_d = 2'd3;
						end
					endcase
					if (q_item.lead != LEAD_ONE && last_b) begin
						acc_d = '0; pend_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
						emit  = 1'b1;
						st    = ST_TRUNC;
					end
				end else begin
					acc_new = {acc_q[ACC_W-7:0], q_item.data[5:0]};
					acc_d   = acc_new;
					pend_d  = pend_q - 2'd1;
					if (pend_d == 2'd0) begin
						acc_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
						emit  = 1'b1;
						cp    = acc_new[CP_W-1:0];
					end else if (last_b) begin
						acc_d = '0; pend_d = '0; idx_d = '0; hi_d = '0; sp_d = 1'b0;
						emit  = 1'b1;
						st    = ST_TRUNC;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_UTF8;
			acc_q       <= '0;
			pend_q      <= '0;
			idx_q       <= '0;
			hi_q        <= '0;
			sp_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fmt_we) begin
				fmt_q  <= fmt_wdata;
				acc_q  <= '0;
				pend_q <= '0;
				idx_q  <= '0;
				hi_q   <= '0;
				sp_q   <= 1'b0;
			end else if (q_pop) begin
				acc_q  <= acc_d;
				pend_q <= pend_d;
				idx_q  <= idx_d;
				hi_q   <= hi_d;
				sp_q   <= sp_d;
			end
			if (q_pop) begin
				out_valid_q <= emit;
			end else if (char_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			cp_q   <= cp;
			st_q   <= st;
			last_q <= last_b;
		end
	end

	assign char_ch.valid      = out_valid_q;
	assign char_ch.code_point = cp_q;
	assign char_ch.status     = st_q;
	assign char_ch.last       = last_q;
endmodule

// ===== rtl/unicode_byte_stream_decoder.sv =====
// top level: unicode byte stream decoder, bytes in, code points out
// byte_ch carries one encoded byte per item with end_of_buffer on the final
// byte; char_ch carries code_point, status and last, one item per finished
// character or error. source_format selects utf-8, utf-16le/be or
// utf-32le/be; each write also drops any partial character, and the user
// must make it while no item is in flight; the block does not enforce this.
// throughput is one byte per cycle while char_ch does not stall; the back
// end decodes one queued item per cycle with a shift-and-or update of its
// accumulator. the byte that completes a result is written into the queue,
// then decoded when popped, and the result is held in the output register.
// a two-item queue separates the classifying front end from the decoder, and
// the result sits in an output register. when char_ch stalls, the queue fills
// and byte_ch.ready drops once two items wait behind the held result.
// reset clears the format to utf-8, all decoding state, the queue pointers
// and count and the output valid flag; no result is pending after reset.
module unicode_byte_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	ubsd_byte_if.sink                   byte_ch,
	ubsd_char_if.source                 char_ch,
	input  logic                        source_format_we,
	input  logic [ubsd_pkg::FMT_W-1:0]  source_format_data
);
	import ubsd_pkg::*;

	logic  q_full;
	logic  q_push;
	item_t q_in_item;
	logic  q_pop;
	item_t q_out_item;
	logic  q_valid;

	ubsd_front u_front (
		.byte_ch (byte_ch),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_in_item)
	);

	ubsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out_item),
		.not_empty (q_valid)
	);

	ubsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt_we    (source_format_we),
		.fmt_wdata (source_format_data),
		.q_valid   (q_valid),
		.q_item    (q_out_item),
		.q_pop     (q_pop),
		.char_ch   (char_ch)
	);
endmodule
